>>> rtl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared command codes, timing constants, and the queue entry type.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

	localparam int CMD_W = 3;

	// decoded command kinds; unused func codes decode to CMD_NONE
	localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEND     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WAIT_ACK = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

	// tick delays
	localparam logic [2:0] HOLD_SETUP = 3'd5;
	localparam logic [2:0] HOLD_LONG  = 3'd6;
	localparam logic [2:0] HOLD_SHORT = 3'd2;
	localparam logic [2:0] HOLD_ONE   = 3'd1;

	localparam logic [7:0] TIMEOUT_RESET = 8'd250;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// front-to-back queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       tx_data;
		logic             ack_after_read;
		logic             sda_in;
	} tick_item_t;

endpackage

>>> rtl/i2cbs_front.sv
// ----------------------------------------------------------------------------
// I2C bit sequencer front end
// Accepts tick items, decodes the command code and queues them for the back end.
// ----------------------------------------------------------------------------
module i2cbs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,   // tx_data[7:0], ack_after_read, sda_in, zero pad
	input  logic [2:0]             s_tuser,   // func
	output logic                   q_valid,
	input  logic                   q_ready,
	output i2cbs_pkg::tick_item_t  q_item
);

	i2cbs_pkg::tick_item_t                 entry_q [i2cbs_pkg::Q_DEPTH];
	logic [i2cbs_pkg::Q_PTR_W-1:0]         wr_ptr_q;
	logic [i2cbs_pkg::Q_PTR_W-1:0]         rd_ptr_q;
	logic [i2cbs_pkg::Q_CNT_W-1:0]         count_q;
	i2cbs_pkg::tick_item_t                 in_item;
	logic                                  push;
	logic                                  pop;

	always_comb begin
		case (s_tuser)
			i2cbs_pkg::CMD_START:    in_item.cmd = i2cbs_pkg::CMD_START;
			i2cbs_pkg::CMD_STOP:     in_item.cmd = i2cbs_pkg::CMD_STOP;
			i2cbs_pkg::CMD_SEND:     in_item.cmd = i2cbs_pkg::CMD_SEND;
			i2cbs_pkg::CMD_WAIT_ACK: in_item.cmd = i2cbs_pkg::CMD_WAIT_ACK;
			i2cbs_pkg::CMD_READ:     in_item.cmd = i2cbs_pkg::CMD_READ;
			default:                 in_item.cmd = i2cbs_pkg::CMD_NONE;
		endcase
		in_item.tx_data        = s_tdata[7:0];
		in_item.ack_after_read = s_tdata[8];
		in_item.sda_in         = s_tdata[9];
	end

	assign s_tready = (count_q != i2cbs_pkg::Q_CNT_W'(i2cbs_pkg::Q_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/i2cbs_back.sv
// ----------------------------------------------------------------------------
// I2C bit sequencer back end
// Steps the bus sequencer once per queued tick and registers the result item.
// ----------------------------------------------------------------------------
module i2cbs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [7:0]             cfg_wdata,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  i2cbs_pkg::tick_item_t  q_item,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata
);

	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_ST1     = 5'd1;
	localparam logic [4:0] PH_ST2     = 5'd2;
	localparam logic [4:0] PH_SP1     = 5'd3;
	localparam logic [4:0] PH_SP2     = 5'd4;
	localparam logic [4:0] PH_TX_LO   = 5'd5;
	localparam logic [4:0] PH_TX_HI   = 5'd6;
	localparam logic [4:0] PH_TX_TAIL = 5'd7;
	localparam logic [4:0] PH_WA1     = 5'd8;
	localparam logic [4:0] PH_WA_POLL = 5'd9;
	localparam logic [4:0] PH_RD_LO   = 5'd10;
	localparam logic [4:0] PH_RD_HI   = 5'd11;
	localparam logic [4:0] PH_AK_LO   = 5'd12;
	localparam logic [4:0] PH_AK_HI   = 5'd13;

	logic [7:0]  timeout_q;
	logic [4:0]  phase_q, n_phase;
	logic [2:0]  delay_q, n_delay;
	logic [3:0]  bit_cnt_q, n_bit_cnt;
	logic [7:0]  shift_q, n_shift;
	logic [7:0]  poll_q, n_poll;
	logic        ack_choice_q, n_ack_choice;
	logic        fail_q, n_fail;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        sda_en_q, n_sda_en;
	logic [7:0]  rx_q, n_rx;
	logic        done;
	logic        act;
	logic        step;
	logic        out_valid_q;
	logic [15:0] out_data_q;

	assign q_ready  = !out_valid_q || m_tready;
	assign step     = q_valid && q_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		n_phase      = phase_q;
		n_delay      = delay_q;
		n_bit_cnt    = bit_cnt_q;
		n_shift      = shift_q;
		n_poll       = poll_q;
		n_ack_choice = ack_choice_q;
		n_fail       = fail_q;
		n_scl        = scl_q;
		n_sda        = sda_q;
		n_sda_en     = sda_en_q;
		n_rx         = rx_q;
		done         = 1'b0;
		act          = 1'b1;

		if (phase_q == PH_IDLE) begin
			case (q_item.cmd)
				i2cbs_pkg::CMD_START: begin
					n_sda_en = 1'b1;
					n_sda    = 1'b1;
					n_scl    = 1'b1;
					n_delay  = i2cbs_pkg::HOLD_SETUP;
					n_phase  = PH_ST1;
				end
				i2cbs_pkg::CMD_STOP: begin
					n_sda_en = 1'b1;
					n_sda    = 1'b0;
					n_scl    = 1'b1;
					n_delay  = i2cbs_pkg::HOLD_LONG;
					n_phase  = PH_SP1;
				end
				i2cbs_pkg::CMD_SEND: begin
					n_sda_en  = 1'b1;
					n_scl     = 1'b0;
					n_bit_cnt = '0;
					n_sda     = q_item.tx_data[7];
					n_shift   = {q_item.tx_data[6:0], 1'b0};
					n_delay   = i2cbs_pkg::HOLD_SHORT;
					n_phase   = PH_TX_LO;
				end
				i2cbs_pkg::CMD_WAIT_ACK: begin
					n_fail   = 1'b0;
					n_sda_en = 1'b1;
					n_sda    = 1'b1;
					n_delay  = i2cbs_pkg::HOLD_ONE;
					n_phase  = PH_WA1;
				end
				i2cbs_pkg::CMD_READ: begin
					n_sda_en     = 1'b0;
					n_ack_choice = q_item.ack_after_read;
					n_bit_cnt    = '0;
					n_shift      = '0;
					n_scl        = 1'b0;
					n_delay      = i2cbs_pkg::HOLD_SHORT;
					n_phase      = PH_RD_LO;
				end
				default: begin
				end
			endcase
		end else begin
			if (delay_q != '0) begin
				n_delay = delay_q - 3'd1;
				act     = (n_delay == '0);
			end
			if (act) begin
				case (phase_q)
					PH_ST1: begin
						n_sda   = 1'b0;
						n_delay = i2cbs_pkg::HOLD_LONG;
						n_phase = PH_ST2;
					end
					PH_ST2: begin
						n_scl = 1'b0;
						done  = 1'b1;
					end
					PH_SP1: begin
						n_sda   = 1'b1;
						n_delay = i2cbs_pkg::HOLD_LONG;
						n_phase = PH_SP2;
					end
					PH_SP2: begin
						done = 1'b1;
					end
					PH_TX_LO: begin
						n_scl   = 1'b1;
						n_delay = i2cbs_pkg::HOLD_SHORT;
						n_phase = PH_TX_HI;
					end
					PH_TX_HI: begin
						n_scl   = 1'b0;
						n_delay = i2cbs_pkg::HOLD_SHORT;
						n_phase = PH_TX_TAIL;
					end
					PH_TX_TAIL: begin
						n_bit_cnt = bit_cnt_q + 4'd1;
						if (n_bit_cnt >= i2cbs_pkg::BITS_PER_BYTE) begin
							done = 1'b1;
						end else begin
							n_sda   = shift_q[7];
							n_shift = {shift_q[6:0], 1'b0};
							n_delay = i2cbs_pkg::HOLD_SHORT;
							n_phase = PH_TX_LO;
						end
					end
					PH_WA1: begin
						n_sda_en = 1'b0;
						n_scl    = 1'b1;
						n_poll   = '0;
						n_delay  = i2cbs_pkg::HOLD_ONE;
						n_phase  = PH_WA_POLL;
					end
					PH_WA_POLL: begin
						if (!q_item.sda_in) begin
							n_scl = 1'b0;
							done  = 1'b1;
						end else if (poll_q >= timeout_q) begin
							// timed out: flag it and release the bus with a stop
							n_fail   = 1'b1;
							n_sda_en = 1'b1;
							n_sda    = 1'b0;
							n_scl    = 1'b1;
							n_delay  = i2cbs_pkg::HOLD_LONG;
							n_phase  = PH_SP1;
						end else begin
							n_poll = poll_q + 8'd1;
						end
					end
					PH_RD_LO: begin
						n_scl   = 1'b1;
						n_shift = {shift_q[6:0], q_item.sda_in};
						n_delay = i2cbs_pkg::HOLD_ONE;
						n_phase = PH_RD_HI;
					end
					PH_RD_HI: begin
						n_bit_cnt = bit_cnt_q + 4'd1;
						n_scl     = 1'b0;
						if (n_bit_cnt < i2cbs_pkg::BITS_PER_BYTE) begin
							n_delay = i2cbs_pkg::HOLD_SHORT;
							n_phase = PH_RD_LO;
						end else begin
							n_rx     = shift_q;
							n_sda_en = 1'b1;
							n_sda    = !ack_choice_q;
							n_delay  = i2cbs_pkg::HOLD_SHORT;
							n_phase  = PH_AK_LO;
						end
					end
					PH_AK_LO: begin
						n_scl   = 1'b1;
						n_delay = i2cbs_pkg::HOLD_SETUP;
						n_phase = PH_AK_HI;
					end
					PH_AK_HI: begin
						n_scl = 1'b0;
						done  = 1'b1;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			if (done) begin
				n_phase = PH_IDLE;
				n_delay = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2cbs_pkg::TIMEOUT_RESET;
		end else if (cfg_wen) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			delay_q      <= '0;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			poll_q       <= '0;
			ack_choice_q <= 1'b0;
			fail_q       <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			sda_en_q     <= 1'b1;
			rx_q         <= '0;
		end else if (step) begin
			phase_q      <= n_phase;
			delay_q      <= n_delay;
			bit_cnt_q    <= n_bit_cnt;
			shift_q      <= n_shift;
			poll_q       <= n_poll;
			ack_choice_q <= n_ack_choice;
			fail_q       <= n_fail;
			scl_q        <= n_scl;
			sda_q        <= n_sda;
			sda_en_q     <= n_sda_en;
			rx_q         <= n_rx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {2'b00, n_fail, n_rx, done, (n_phase != PH_IDLE),
				n_sda_en, n_sda, n_scl};
		end
	end

endmodule

>>> rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Tick-driven I2C master: start, stop, byte send, ack wait and byte read.
// ----------------------------------------------------------------------------
// Each input item is one bus tick; it carries an optional command (func) and
// the sampled SDA level, and yields exactly one result item with the SCL, SDA
// and SDA-enable levels after that tick plus busy, done, the last received
// byte and the ack-failure flag. Commands are only taken while idle. The
// front end decodes and queues up to four items; the back end steps the
// sequencer state once per item into an output register, so one item per
// clock is sustained while m_tready is high; queue and output are registered.
// cfg_wen/cfg_wdata set the ack poll timeout; write it only while idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,   // ack_timeout_polls
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // tx_data[7:0], ack_after_read, sda_in, zero pad
	input  logic [2:0]  s_tuser,     // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // scl, sda_out, sda_drive, busy_res, done_res,
	                                 // rx_data[7:0], ack_failed, zero pad
);

	logic                  q_valid;
	logic                  q_ready;
	i2cbs_pkg::tick_item_t q_item;

	i2cbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	i2cbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> dv/i2c_master_bit_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Streams bus ticks into the sequencer and checks every result item against
// an in-bench model of the start, stop, send, ack-wait and read sequences.
// A short table of directed ticks comes first, then runs of well-formed bus
// transactions mixed with stray commands, under several ack poll timeouts.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_test;

	// func codes the block must ignore
	localparam logic [i2cbs_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [i2cbs_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	localparam int ITEMS_TOTAL = 1050;
	localparam int NUM_PHASES  = 4;

	typedef enum logic [3:0] {
		SQ_IDLE, SQ_START_SETUP, SQ_START_HOLD, SQ_STOP_LOW, SQ_STOP_HIGH,
		SQ_TX_LOW, SQ_TX_HIGH, SQ_TX_TAIL, SQ_ACK_DRIVE, SQ_ACK_POLL,
		SQ_RD_LOW, SQ_RD_HIGH, SQ_RACK_LOW, SQ_RACK_HIGH
	} seq_phase_t;

	typedef struct packed {
		logic                        is_cfg;
		logic [i2cbs_pkg::CMD_W-1:0] func;
		logic [7:0]                  txd;    // register value on config rows
		logic                        ack;
		logic                        sda;
		logic [8:0]                  reps;
		logic                        settle; // pad with empty ticks until idle
		logic                        typed;
		logic [15:0]                 levels;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic [2:0]  s_tuser = 3'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// model state
	seq_phase_t ph;
	logic [2:0] dly;
	logic [3:0] nbits;
	logic [7:0] shreg, polls, timeout_polls, rx_byte;
	logic       ack_sel, failed, scl_q, sda_q, sda_oe;

	logic [15:0] pending_levels_q[$];
	stim_row_t   stim_rows[$];
	logic [15:0] want_levels;
	int          mismatches = 0;
	int          items_sent = 0;
	int          phase_limit = 0;
	logic        calm = 1'b0;

	i2c_master_bit_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // tx_data[7:0], ack_after_read, sda_in, zero pad
		.s_tuser  (s_tuser),   // func
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // scl, sda_out, sda_drive, busy_res, done_res,
		                       // rx_data[7:0], ack_failed, zero pad
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 19);
	end

	task automatic reset_sequencer_model();
		timeout_polls = i2cbs_pkg::TIMEOUT_RESET;
		ph = SQ_IDLE;
		dly = 3'd0; nbits = 4'd0; shreg = 8'd0; polls = 8'd0;
		ack_sel = 1'b0; failed = 1'b0; rx_byte = 8'd0;
		scl_q = 1'b1; sda_q = 1'b1; sda_oe = 1'b1;
	endtask

	task automatic load_next_bit();
		sda_q = shreg[7];
		shreg = {shreg[6:0], 1'b0};
		dly = i2cbs_pkg::HOLD_SHORT;
		ph = SQ_TX_LOW;
	endtask

	task automatic enter_stop();
		sda_oe = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
		dly = i2cbs_pkg::HOLD_LONG;
		ph = SQ_STOP_LOW;
	endtask

	// one tick of the sequencer; returns the packed line levels and status
	task automatic bus_levels_after_tick(input logic [i2cbs_pkg::CMD_W-1:0] f,
			input logic [7:0] txd, input logic ack, input logic sda,
			output logic [15:0] levels);
		logic fin;
		logic act;
		fin = 1'b0;
		if (ph == SQ_IDLE) begin
			case (f)
				i2cbs_pkg::CMD_START: begin
					sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
					dly = i2cbs_pkg::HOLD_SETUP; ph = SQ_START_SETUP;
				end
				i2cbs_pkg::CMD_STOP: enter_stop();
				i2cbs_pkg::CMD_SEND: begin
					sda_oe = 1'b1; scl_q = 1'b0;
					shreg = txd; nbits = 4'd0;
					load_next_bit();
				end
				i2cbs_pkg::CMD_WAIT_ACK: begin
					failed = 1'b0; sda_oe = 1'b1; sda_q = 1'b1;
					dly = i2cbs_pkg::HOLD_ONE; ph = SQ_ACK_DRIVE;
				end
				i2cbs_pkg::CMD_READ: begin
					sda_oe = 1'b0; ack_sel = ack;
					nbits = 4'd0; shreg = 8'd0; scl_q = 1'b0;
					dly = i2cbs_pkg::HOLD_SHORT; ph = SQ_RD_LOW;
				end
				default: ;
			endcase
		end else begin
			act = 1'b1;
			if (dly != 3'd0) begin
				dly = dly - 3'd1;
				act = (dly == 3'd0);
			end
			if (act) begin
				case (ph)
					SQ_START_SETUP: begin
						sda_q = 1'b0; dly = i2cbs_pkg::HOLD_LONG; ph = SQ_START_HOLD;
					end
					SQ_START_HOLD: begin
						scl_q = 1'b0; fin = 1'b1;
					end
					SQ_STOP_LOW: begin
						sda_q = 1'b1; dly = i2cbs_pkg::HOLD_LONG; ph = SQ_STOP_HIGH;
					end
					SQ_STOP_HIGH: fin = 1'b1;
					SQ_TX_LOW: begin
						scl_q = 1'b1; dly = i2cbs_pkg::HOLD_SHORT; ph = SQ_TX_HIGH;
					end
					SQ_TX_HIGH: begin
						scl_q = 1'b0; dly = i2cbs_pkg::HOLD_SHORT; ph = SQ_TX_TAIL;
					end
					SQ_TX_TAIL: begin
						nbits = nbits + 4'd1;
						if (nbits >= i2cbs_pkg::BITS_PER_BYTE) fin = 1'b1;
						else load_next_bit();
					end
					SQ_ACK_DRIVE: begin
						sda_oe = 1'b0; scl_q = 1'b1; polls = 8'd0;
						dly = i2cbs_pkg::HOLD_ONE; ph = SQ_ACK_POLL;
					end
					SQ_ACK_POLL: begin
						if (!sda) begin
							scl_q = 1'b0; fin = 1'b1;
						end else if (polls >= timeout_polls) begin
							failed = 1'b1;
							enter_stop();
						end else begin
							polls = polls + 8'd1;
						end
					end
					SQ_RD_LOW: begin
						scl_q = 1'b1;
						shreg = {shreg[6:0], sda};
						dly = i2cbs_pkg::HOLD_ONE; ph = SQ_RD_HIGH;
					end
					SQ_RD_HIGH: begin
						nbits = nbits + 4'd1;
						scl_q = 1'b0;
						if (nbits < i2cbs_pkg::BITS_PER_BYTE) begin
							dly = i2cbs_pkg::HOLD_SHORT; ph = SQ_RD_LOW;
						end else begin
							rx_byte = shreg;
							sda_oe = 1'b1;
							sda_q = ack_sel ? 1'b0 : 1'b1;
							dly = i2cbs_pkg::HOLD_SHORT; ph = SQ_RACK_LOW;
						end
					end
					SQ_RACK_LOW: begin
						scl_q = 1'b1; dly = i2cbs_pkg::HOLD_SETUP; ph = SQ_RACK_HIGH;
					end
					SQ_RACK_HIGH: begin
						scl_q = 1'b0; fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			if (fin) begin
				ph = SQ_IDLE;
				dly = 3'd0;
			end
		end
		levels = {2'b00, failed, rx_byte, fin, ph != SQ_IDLE, sda_oe, sda_q, scl_q};
	endtask

	// offer one tick item, wait for it to be taken, then log what it should produce
	task automatic send_tick(input logic [i2cbs_pkg::CMD_W-1:0] f, input logic [7:0] txd,
			input logic ack, input logic sda, input logic typed, input logic [15:0] levels);
		logic        taken;
		logic [15:0] model_levels;
		while (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {6'd0, sda, ack, txd};
		// tready is stable by the falling edge, so the next rising edge decides
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		bus_levels_after_tick(f, txd, ack, sda, model_levels);
		pending_levels_q.push_back(typed ? levels : model_levels);
	endtask

	// finish the running sequence, then hold off until every result is out
	task automatic drain_bus();
		while (ph != SQ_IDLE)
			send_tick(i2cbs_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'b0, 16'd0);
		s_tvalid <= 1'b0;
		while (pending_levels_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_timeout(input logic [7:0] value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		timeout_polls = value;
	endtask

	// start a command and tick until it completes; poll_plan is the number of
	// high polls before the target pulls SDA low during an ack wait
	task automatic issue(input logic [i2cbs_pkg::CMD_W-1:0] f, input logic [7:0] txd,
			input logic ack, input int poll_plan);
		int   seen;
		logic s;
		seen = 0;
		// item budget for this phase used up: start nothing new
		if (items_sent >= phase_limit) return;
		send_tick(f, txd, ack, 1'($urandom_range(1)), 1'b0, 16'd0);
		while (ph != SQ_IDLE) begin
			if (ph == SQ_ACK_POLL && $urandom_range(19) != 0) begin
				s = (seen >= poll_plan) ? 1'b0 : 1'b1;
				seen++;
			end else begin
				s = 1'($urandom_range(1));
			end
			// busy ticks carry random func, which must be ignored
			send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), s,
				1'b0, 16'd0);
		end
	endtask

	function automatic int pick_poll_plan();
		if ($urandom_range(99) < 10) return $urandom_range(0, 300);
		return $urandom_range(0, 3);
	endfunction

	task automatic bus_transaction();
		int n;
		issue(i2cbs_pkg::CMD_START, 8'($urandom), 1'($urandom_range(1)), 0);
		issue(i2cbs_pkg::CMD_SEND, 8'($urandom), 1'($urandom_range(1)), 0);
		issue(i2cbs_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom_range(1)), pick_poll_plan());
		if (failed) return;
		n = $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(1)) begin
				issue(i2cbs_pkg::CMD_SEND, 8'($urandom), 1'($urandom_range(1)), 0);
				issue(i2cbs_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom_range(1)),
					pick_poll_plan());
			end else begin
				issue(i2cbs_pkg::CMD_READ, 8'($urandom), 1'($urandom_range(1)), 0);
			end
		end
		issue(i2cbs_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(1)), 0);
	endtask

	task automatic add_row(input logic is_cfg, input logic [i2cbs_pkg::CMD_W-1:0] f,
			input logic [7:0] txd, input logic ack, input logic sda, input logic [8:0] reps,
			input logic settle, input logic typed, input logic [15:0] levels);
		stim_row_t r;
		r.is_cfg = is_cfg; r.func = f; r.txd = txd; r.ack = ack; r.sda = sda;
		r.reps = reps; r.settle = settle; r.typed = typed; r.levels = levels;
		stim_rows.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_levels_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result item with nothing pending: %h", m_tdata);
			end else begin
				want_levels = pending_levels_q.pop_front();
				if (m_tdata !== want_levels) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp/act: scl %b/%b sda %b/%b oe %b/%b busy %b/%b ",
							"done %b/%b rx %h/%h fail %b/%b pad %b/%b"},
							want_levels[0], m_tdata[0], want_levels[1], m_tdata[1],
							want_levels[2], m_tdata[2], want_levels[3], m_tdata[3],
							want_levels[4], m_tdata[4], want_levels[12:5], m_tdata[12:5],
							want_levels[13], m_tdata[13], want_levels[15:14], m_tdata[15:14]);
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t  row;
		logic [7:0] tmo;
		int         random_base;
		int         slice;
		reset_sequencer_model();

		// lines idle high after reset; unused codes change nothing
		add_row(1'b0, i2cbs_pkg::CMD_NONE,     8'h00, 1'b0, 1'b0, 9'd1,  1'b0, 1'b1, 16'h0007);
		add_row(1'b0, CMD_UNUSED_LO,           8'hFF, 1'b1, 1'b1, 9'd1,  1'b0, 1'b1, 16'h0007);
		add_row(1'b0, CMD_UNUSED_HI,           8'h00, 1'b0, 1'b0, 9'd1,  1'b0, 1'b1, 16'h0007);
		add_row(1'b0, i2cbs_pkg::CMD_START,    8'h00, 1'b0, 1'b1, 9'd1,  1'b0, 1'b1, 16'h000F);
		add_row(1'b0, i2cbs_pkg::CMD_NONE,     8'h00, 1'b0, 1'b0, 9'd10, 1'b0, 1'b0, 16'd0);
		// stop lands on the completing tick of the start and is dropped
		add_row(1'b0, i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_SEND,     8'hFF, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_SEND,     8'h00, 1'b1, 1'b1, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_READ,     8'h00, 1'b1, 1'b1, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_READ,     8'hFF, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		// no ack at the reset timeout: stop is issued and the flag set
		add_row(1'b0, i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 1'b1, 9'd1,  1'b1, 1'b0, 16'd0);
		// zero timeout: the first high poll fails
		add_row(1'b1, i2cbs_pkg::CMD_NONE,     8'h00, 1'b0, 1'b0, 9'd0,  1'b0, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 9'd1,  1'b1, 1'b0, 16'd0);
		// widest timeout, acked on the first poll
		add_row(1'b1, i2cbs_pkg::CMD_NONE,     8'hFF, 1'b0, 1'b0, 9'd0,  1'b0, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_START,    8'h00, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_SEND,     8'hA5, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);
		add_row(1'b0, i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 1'b0, 9'd1,  1'b1, 1'b0, 16'd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_rows.size(); i++) begin
			row = stim_rows[i];
			if (row.is_cfg) begin
				drain_bus();
				set_timeout(row.txd);
			end else begin
				repeat (row.reps)
					send_tick(row.func, row.txd, row.ack, row.sda, row.typed, row.levels);
				if (row.settle)
					while (ph != SQ_IDLE)
						send_tick(i2cbs_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)),
							row.sda, 1'b0, 16'd0);
			end
		end

		// split what is left of the item budget evenly over the phases
		random_base = items_sent;
		slice = (ITEMS_TOTAL > random_base) ? (ITEMS_TOTAL - random_base) / NUM_PHASES : 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: tmo = 8'd1;
				1: tmo = 8'hFF;
				3: tmo = i2cbs_pkg::TIMEOUT_RESET;
				default: tmo = 8'($urandom_range(2, 254));
			endcase
			drain_bus();
			set_timeout(tmo);
			calm = (p == 2);
			phase_limit = random_base + (p + 1) * slice;
			while (items_sent < phase_limit) begin
				if ($urandom_range(99) < 15) begin
					// stray command out of sequence, any code
					issue(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
						$urandom_range(0, 8));
					repeat ($urandom_range(0, 3))
						send_tick(i2cbs_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'b0, 16'd0);
				end else begin
					bus_transaction();
				end
			end
		end
		calm = 1'b0;

		drain_bus();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_levels_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
